FILE: hdl/los_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line-of-sight package
// Shared constants, payload types, the arctangent table and the back-end
// state type for the line-of-sight test block.
// ----------------------------------------------------------------------------
package los_pkg;

   localparam int MAX_WALLS    = 64;
   localparam int WALL_IDX_W   = $clog2(MAX_WALLS);
   localparam int WALL_CNT_W   = 7;
   localparam int COORD_BITS   = 16;
   localparam int DIFF_W       = COORD_BITS + 1;
   localparam int PROD_W       = 2 * DIFF_W;
   localparam int CROSS_W      = PROD_W + 1;
   localparam int ANGLE_BITS   = 16;
   localparam int ACC_W        = 32;
   localparam int CORDIC_STEPS = 30;
   localparam int STEP_W       = $clog2(CORDIC_STEPS);
   localparam int CORDIC_SHIFT = 61 - COORD_BITS;
   localparam int FIFO_DEPTH   = 2;
   localparam int CSR_DATA_W   = 16;

   // Register indexes on the configuration port.
   localparam logic CSR_WALL_COUNT = 1'b0;
   localparam logic CSR_FOV_HALF   = 1'b1;

   // Request modes.
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef struct packed {
      logic                          mode;
      logic [WALL_IDX_W-1:0]         wall_index;
      logic signed [COORD_BITS-1:0]  wall_x0;
      logic signed [COORD_BITS-1:0]  wall_y0;
      logic signed [COORD_BITS-1:0]  wall_x1;
      logic signed [COORD_BITS-1:0]  wall_y1;
      logic signed [COORD_BITS-1:0]  player_x;
      logic signed [COORD_BITS-1:0]  player_y;
      logic [ANGLE_BITS-1:0]         facing_angle;
      logic signed [COORD_BITS-1:0]  aim_x;
      logic signed [COORD_BITS-1:0]  aim_y;
   } req_type;

   typedef struct packed {
      logic                  visible;
      logic                  in_fov;
      logic                  blocked;
      logic [WALL_IDX_W-1:0] blocking_wall;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x0;
      logic signed [COORD_BITS-1:0] y0;
      logic signed [COORD_BITS-1:0] x1;
      logic signed [COORD_BITS-1:0] y1;
   } wall_type;

   // Classified request as it sits in the queue.
   typedef struct packed {
      logic                         is_load;
      logic [WALL_IDX_W-1:0]        wall_index;
      wall_type                     wall;
      logic signed [COORD_BITS-1:0] player_x;
      logic signed [COORD_BITS-1:0] player_y;
      logic signed [COORD_BITS-1:0] aim_x;
      logic signed [COORD_BITS-1:0] aim_y;
      logic [ANGLE_BITS-1:0]        facing_angle;
      logic                         at_player;
      logic                         half_turn;
      logic signed [DIFF_W-1:0]     u0;
      logic signed [DIFF_W-1:0]     v0;
   } item_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } back_state_type;

   // atan(2^-i) in 2^32-per-turn units.
   function automatic logic [ACC_W-1:0] atan_lut(input logic [STEP_W-1:0] i);
      logic [ACC_W-1:0] r;
      begin
         case (i)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2F9;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029;
            5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A;
            5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000003;
            5'd29: r = 32'h00000001;
            default: r = '0;
         endcase
         return r;
      end
   endfunction

endpackage

FILE: hdl/los_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line-of-sight front end
// Accepts requests, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module los_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  los_pkg::req_type  req,
   input  logic              pop,
   output logic              item_valid,
   output los_pkg::item_type item
);
   import los_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);

   item_type                   entry_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]             count_ff, count_in;
   item_type                   cls;
   logic signed [DIFF_W-1:0]   u, v;
   logic                       push;

   // Sight direction relative to up; the lower half-plane is folded over.
   always_comb begin
      u = DIFF_W'(req.player_y) - DIFF_W'(req.aim_y);
      v = DIFF_W'(req.aim_x) - DIFF_W'(req.player_x);
      cls.is_load      = (req.mode == MODE_LOAD);
      cls.wall_index   = req.wall_index;
      cls.wall.x0      = req.wall_x0;
      cls.wall.y0      = req.wall_y0;
      cls.wall.x1      = req.wall_x1;
      cls.wall.y1      = req.wall_y1;
      cls.player_x     = req.player_x;
      cls.player_y     = req.player_y;
      cls.aim_x        = req.aim_x;
      cls.aim_y        = req.aim_y;
      cls.facing_angle = req.facing_angle;
      cls.at_player    = (u == '0) && (v == '0);
      cls.half_turn    = u[DIFF_W-1];
      cls.u0           = u[DIFF_W-1] ? -u : u;
      cls.v0           = u[DIFF_W-1] ? -v : v;
   end

   assign busy       = (count_ff == (PTR_W+1)'(FIFO_DEPTH));
   assign push       = start && !busy;
   assign item_valid = (count_ff != '0);
   assign item       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

FILE: hdl/los_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line-of-sight bearing unit
// Vectoring CORDIC, one micro-rotation per cycle, giving the target bearing.
// ----------------------------------------------------------------------------
module los_cordic (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    begin_run,
   input  logic                                    at_player,
   input  logic                                    half_turn,
   input  logic signed [los_pkg::DIFF_W-1:0]       u0,
   input  logic signed [los_pkg::DIFF_W-1:0]       v0,
   output logic                                    done,
   output logic [los_pkg::ANGLE_BITS-1:0]          bearing
);
   import los_pkg::*;

   localparam int W = 64;

   logic signed [W-1:0] u_ff, u_in, v_ff, v_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                running_ff, running_in;
   logic                done_ff, done_in;
   logic                zero_ff, zero_in;
   logic signed [W-1:0] du, dv;
   logic [ACC_W-1:0]    rounded;

   always_comb begin
      u_in       = u_ff;
      v_in       = v_ff;
      acc_in     = acc_ff;
      step_in    = step_ff;
      running_in = running_ff;
      done_in    = done_ff;
      zero_in    = zero_ff;
      du         = v_ff >>> step_ff;
      dv         = u_ff >>> step_ff;
      if (begin_run) begin
         u_in       = W'(u0) <<< CORDIC_SHIFT;
         v_in       = W'(v0) <<< CORDIC_SHIFT;
         acc_in     = {half_turn, {(ACC_W-1){1'b0}}};
         step_in    = '0;
         zero_in    = at_player;
         running_in = !at_player;
         done_in    = at_player;
      end else if (running_ff) begin
         if (!v_ff[W-1]) begin
            u_in   = u_ff + du;
            v_in   = v_ff - dv;
            acc_in = acc_ff + atan_lut(step_ff);
         end else begin
            u_in   = u_ff - du;
            v_in   = v_ff + dv;
            acc_in = acc_ff - atan_lut(step_ff);
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      u_ff    <= u_in;
      v_ff    <= v_in;
      acc_ff  <= acc_in;
      step_ff <= step_in;
      zero_ff <= zero_in;
   end

   assign rounded = acc_ff + (ACC_W'(1) << (ACC_W - 1 - ANGLE_BITS));
   assign done    = done_ff;
   assign bearing = zero_ff ? '0 : rounded[ACC_W-1 -: ANGLE_BITS];

endmodule

FILE: hdl/los_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line-of-sight wall scanner
// Holds the wall table and tests one wall per cycle in a three-stage pipe.
// ----------------------------------------------------------------------------
module los_scan (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 wr_en,
   input  logic [los_pkg::WALL_IDX_W-1:0]       wr_index,
   input  los_pkg::wall_type                    wr_wall,
   input  logic                                 begin_run,
   input  logic [los_pkg::WALL_CNT_W-1:0]       wall_count,
   input  logic signed [los_pkg::COORD_BITS-1:0] ax,
   input  logic signed [los_pkg::COORD_BITS-1:0] ay,
   input  logic signed [los_pkg::COORD_BITS-1:0] bx,
   input  logic signed [los_pkg::COORD_BITS-1:0] by,
   output logic                                 done,
   output logic                                 hit,
   output logic [los_pkg::WALL_IDX_W-1:0]       hit_index
);
   import los_pkg::*;

   wall_type                   mem [MAX_WALLS];
   wall_type                   rd_ff;
   logic [WALL_CNT_W-1:0]      limit;
   logic [WALL_CNT_W-1:0]      issue_ff;
   logic                       issuing_ff;
   logic                       v1_ff, v2_ff;
   logic [WALL_IDX_W-1:0]      k1_ff, k2_ff;
   logic                       hit_ff;
   logic [WALL_IDX_W-1:0]      hit_idx_ff;
   logic signed [DIFF_W-1:0]   cx_ax, by_ay, bx_ax, cy_ay, dx_ax, dy_ay;
   logic signed [DIFF_W-1:0]   ax_cx, dy_cy, dx_cx, ay_cy, bx_cx, by_cy;
   logic signed [PROD_W-1:0]   p_ff [8];
   logic signed [CROSS_W-1:0]  c1, c2, c3, c4;
   logic                       meet;

   assign limit = (wall_count > WALL_CNT_W'(MAX_WALLS)) ?
                  WALL_CNT_W'(MAX_WALLS) : wall_count;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_index] <= wr_wall;
      end
      rd_ff <= mem[issue_ff[WALL_IDX_W-1:0]];
   end

   always_comb begin
      cx_ax = DIFF_W'(rd_ff.x0) - DIFF_W'(ax);
      cy_ay = DIFF_W'(rd_ff.y0) - DIFF_W'(ay);
      dx_ax = DIFF_W'(rd_ff.x1) - DIFF_W'(ax);
      dy_ay = DIFF_W'(rd_ff.y1) - DIFF_W'(ay);
      bx_ax = DIFF_W'(bx) - DIFF_W'(ax);
      by_ay = DIFF_W'(by) - DIFF_W'(ay);
      ax_cx = DIFF_W'(ax) - DIFF_W'(rd_ff.x0);
      ay_cy = DIFF_W'(ay) - DIFF_W'(rd_ff.y0);
      bx_cx = DIFF_W'(bx) - DIFF_W'(rd_ff.x0);
      by_cy = DIFF_W'(by) - DIFF_W'(rd_ff.y0);
      dx_cx = DIFF_W'(rd_ff.x1) - DIFF_W'(rd_ff.x0);
      dy_cy = DIFF_W'(rd_ff.y1) - DIFF_W'(rd_ff.y0);
   end

   always_ff @(posedge clock) begin
      p_ff[0] <= PROD_W'(cx_ax) * PROD_W'(by_ay);
      p_ff[1] <= PROD_W'(bx_ax) * PROD_W'(cy_ay);
      p_ff[2] <= PROD_W'(dx_ax) * PROD_W'(by_ay);
      p_ff[3] <= PROD_W'(bx_ax) * PROD_W'(dy_ay);
      p_ff[4] <= PROD_W'(ax_cx) * PROD_W'(dy_cy);
      p_ff[5] <= PROD_W'(dx_cx) * PROD_W'(ay_cy);
      p_ff[6] <= PROD_W'(bx_cx) * PROD_W'(dy_cy);
      p_ff[7] <= PROD_W'(dx_cx) * PROD_W'(by_cy);
      k1_ff   <= issue_ff[WALL_IDX_W-1:0];
      k2_ff   <= k1_ff;
   end

   // Segments meet when neither pair of cross products has strictly equal signs.
   always_comb begin
      c1 = CROSS_W'(p_ff[0]) - CROSS_W'(p_ff[1]);
      c2 = CROSS_W'(p_ff[2]) - CROSS_W'(p_ff[3]);
      c3 = CROSS_W'(p_ff[4]) - CROSS_W'(p_ff[5]);
      c4 = CROSS_W'(p_ff[6]) - CROSS_W'(p_ff[7]);
      meet = ((c1 == '0) || (c2 == '0) || (c1[CROSS_W-1] != c2[CROSS_W-1])) &&
             ((c3 == '0) || (c4 == '0) || (c3[CROSS_W-1] != c4[CROSS_W-1]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issuing_ff <= 1'b0;
         issue_ff   <= '0;
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         hit_ff     <= 1'b0;
         hit_idx_ff <= '0;
      end else if (begin_run) begin
         issuing_ff <= (limit != '0);
         issue_ff   <= '0;
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         hit_ff     <= 1'b0;
         hit_idx_ff <= '0;
      end else begin
         v1_ff <= issuing_ff && !hit_ff;
         v2_ff <= v1_ff && !hit_ff;
         if (issuing_ff) begin
            issue_ff <= issue_ff + 1'b1;
            if ((issue_ff + 1'b1) == limit || hit_ff) begin
               issuing_ff <= 1'b0;
            end
         end
         if (v2_ff && meet && !hit_ff) begin
            hit_ff     <= 1'b1;
            hit_idx_ff <= k2_ff;
         end
      end
   end

   assign done      = hit_ff || (!issuing_ff && !v1_ff && !v2_ff);
   assign hit       = hit_ff;
   assign hit_index = hit_idx_ff;

endmodule

FILE: hdl/los_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line-of-sight back end
// Pops queued requests, writes walls, runs queries and forms the response.
// ----------------------------------------------------------------------------
module los_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               item_valid,
   input  los_pkg::item_type                  item,
   output logic                               pop,
   input  logic [los_pkg::WALL_CNT_W-1:0]     wall_count,
   input  logic [los_pkg::CSR_DATA_W-1:0]     fov_half_angle,
   output logic                               rsp_valid,
   output los_pkg::rsp_type                   rsp
);
   import los_pkg::*;

   back_state_type              state_ff, state_in;
   item_type                    q_ff;
   logic                        begin_run;
   logic                        cordic_done, scan_done, hit;
   logic [WALL_IDX_W-1:0]       hit_index;
   logic [ANGLE_BITS-1:0]       bearing, diff;
   logic [ANGLE_BITS:0]         mag;
   logic                        in_fov;
   logic                        rsp_valid_ff, rsp_valid_in;
   rsp_type                     rsp_ff, rsp_in;

   always_comb begin
      state_in     = state_ff;
      pop          = 1'b0;
      begin_run    = 1'b0;
      rsp_valid_in = 1'b0;
      diff         = bearing - q_ff.facing_angle;
      mag          = diff[ANGLE_BITS-1] ? ((ANGLE_BITS+1)'(1) << ANGLE_BITS) - {1'b0, diff}
                                        : {1'b0, diff};
      in_fov       = mag <= (ANGLE_BITS+1)'(fov_half_angle);
      rsp_in.visible       = in_fov && !hit;
      rsp_in.in_fov        = in_fov;
      rsp_in.blocked       = hit;
      rsp_in.blocking_wall = hit_index;
      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               pop = 1'b1;
               if (!item.is_load) begin
                  begin_run = 1'b1;
                  state_in  = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (cordic_done && scan_done) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (begin_run) begin
         q_ff <= item;
      end
      if (rsp_valid_in) begin
         rsp_ff <= rsp_in;
      end
   end

   los_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .begin_run (begin_run),
      .at_player (item.at_player),
      .half_turn (item.half_turn),
      .u0        (item.u0),
      .v0        (item.v0),
      .done      (cordic_done),
      .bearing   (bearing)
   );

   los_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (pop && item.is_load),
      .wr_index   (item.wall_index),
      .wr_wall    (item.wall),
      .begin_run  (begin_run),
      .wall_count (wall_count),
      .ax         (q_ff.player_x),
      .ay         (q_ff.player_y),
      .bx         (q_ff.aim_x),
      .by         (q_ff.aim_y),
      .done       (scan_done),
      .hit        (hit),
      .hit_index  (hit_index)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

FILE: hdl/line_of_sight_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line-of-sight test
// Wall table plus visibility query: field-of-view check and wall blocking.
// ----------------------------------------------------------------------------
// A request is taken at a clock edge where start is high and busy is low; a
// two-entry queue sits in front of the processing engine, so busy rises only
// when two requests are waiting. A load request writes one wall as it is
// popped. A query runs the bearing CORDIC (one micro-rotation per cycle)
// alongside a wall scan that reads and tests one wall per cycle from the
// table memory; the query is popped from the queue, stays in the engine until
// both are done, and its result goes through the response register. The scan
// stops early when a wall blocks the view. Each query yields exactly one
// response, shown for a single cycle with rsp_valid; the receiver cannot
// stall it and must capture it then. Loads give no response. The user must
// write registers through the csr_ port only while no request is in flight;
// the block itself does not enforce this.
module line_of_sight_test (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  los_pkg::req_type                   req,
   output logic                               rsp_valid,
   output los_pkg::rsp_type                   rsp,
   input  logic                               csr_we,
   input  logic                               csr_index,
   input  logic [los_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import los_pkg::*;

   logic [WALL_CNT_W-1:0] wall_count_ff;
   logic [CSR_DATA_W-1:0] fov_half_ff;
   logic                  item_valid, pop;
   item_type              item;

   // Configuration registers; a half angle of half a turn admits everything.
   always_ff @(posedge clock) begin
      if (reset) begin
         wall_count_ff <= '0;
         fov_half_ff   <= CSR_DATA_W'(8192);
      end else if (csr_we) begin
         case (csr_index)
            CSR_WALL_COUNT: wall_count_ff <= csr_wdata[WALL_CNT_W-1:0];
            CSR_FOV_HALF:   fov_half_ff   <= csr_wdata;
            default:        ;
         endcase
      end
   end

   // The front end classifies each request and queues it.
   los_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req        (req),
      .pop        (pop),
      .item_valid (item_valid),
      .item       (item)
   );

   // The back end carries out loads and queries in arrival order.
   los_back u_back (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (item_valid),
      .item           (item),
      .pop            (pop),
      .wall_count     (wall_count_ff),
      .fov_half_angle (fov_half_ff),
      .rsp_valid      (rsp_valid),
      .rsp            (rsp)
   );

   // A response always ends the query, so two never come back to back.
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two responses in consecutive cycles");

   a_visible: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp.visible == (rsp.in_fov && !rsp.blocked)))
      else $error("visible disagrees with in_fov and blocked");

   a_no_hit_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp.blocked) |-> (rsp.blocking_wall == '0))
      else $error("blocking wall reported without a block");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> (!busy && !rsp_valid))
      else $error("block not idle after reset");

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line-of-sight block testbench
// Loads the wall table, runs visibility queries under several wall counts
// and field-of-view widths, and compares every response with a bit-exact
// bearing and segment-crossing predictor kept inside this bench.
// ----------------------------------------------------------------------------
module tb_top;
   import los_pkg::*;

   // atan(2^-i) in binary-angle units of 2^32 per turn.
   localparam logic [31:0] ATAN_STEP [CORDIC_STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001};

   // Loads leave nothing to wait on, so this pause covers a queued load plus
   // a query still in flight.
   localparam int SETTLE_CYCLES = 200;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_type               req;
   logic                  rsp_valid;
   rsp_type               rsp;
   logic                  csr_we;
   logic                  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Shadow copy of the block's state and registers.
   wall_type   wall_shadow [MAX_WALLS];
   int         walls_enabled;
   int         fov_limit;

   rsp_type    pending_views [$];
   int         error_count;
   int         sender_idle_pct;

   line_of_sight_test dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // A hard stop in case the block hangs or drops responses.
   initial begin
      #5ms;
      $display("line_of_sight_test test failed");
      $finish;
   end

   // Bearing of (dx, dy) by CORDIC vectoring, clockwise from up. The start
   // vector is folded into the upper half plane, then each micro-rotation
   // drives v toward zero while the angle accumulates in 32-bit units.
   function automatic logic [ANGLE_BITS-1:0] bearing_from(longint dx, longint dy);
      longint      u;
      longint      v;
      longint      du;
      longint      dv;
      logic [31:0] acc;
      u   = -dy;
      v   = dx;
      acc = '0;
      if (u == 0 && v == 0) begin
         return '0;
      end
      if (u < 0) begin
         u   = -u;
         v   = -v;
         acc = 32'h80000000;
      end
      u = u <<< CORDIC_SHIFT;
      v = v <<< CORDIC_SHIFT;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         du = v >>> i;
         dv = u >>> i;
         if (v >= 0) begin
            u   = u + du;
            v   = v - dv;
            acc = acc + ATAN_STEP[i];
         end else begin
            u   = u - du;
            v   = v + dv;
            acc = acc - ATAN_STEP[i];
         end
      end
      acc = acc + (32'd1 << (31 - ANGLE_BITS));
      return acc[31 -: ANGLE_BITS];
   endfunction

   // Sign of the cross product (p - o) x (q - o); exact in 64 bits.
   function automatic int turn_sign(longint ox, longint oy, longint px, longint py,
                                    longint qx, longint qy);
      longint c;
      c = (px - ox) * (qy - oy) - (qx - ox) * (py - oy);
      return (c > 0) ? 1 : ((c < 0) ? -1 : 0);
   endfunction

   // Inclusive crossing test: touching and collinear cases count as a hit.
   function automatic bit sight_crosses(req_type r, wall_type w);
      int s1;
      int s2;
      int s3;
      int s4;
      s1 = turn_sign(r.player_x, r.player_y, w.x0, w.y0, r.aim_x, r.aim_y);
      s2 = turn_sign(r.player_x, r.player_y, w.x1, w.y1, r.aim_x, r.aim_y);
      s3 = turn_sign(w.x0, w.y0, r.player_x, r.player_y, w.x1, w.y1);
      s4 = turn_sign(w.x0, w.y0, r.aim_x, r.aim_y, w.x1, w.y1);
      return (s1 * s2 <= 0) && (s3 * s4 <= 0);
   endfunction

   function automatic rsp_type view_of(req_type r);
      rsp_type               e;
      logic [ANGLE_BITS-1:0] diff;
      int                    mag;
      int                    scan;
      e    = '0;
      diff = bearing_from(longint'(r.aim_x) - longint'(r.player_x),
                          longint'(r.aim_y) - longint'(r.player_y)) - r.facing_angle;
      mag  = diff[ANGLE_BITS-1] ? (1 << ANGLE_BITS) - int'(diff) : int'(diff);
      e.in_fov = (mag <= fov_limit);
      scan = (walls_enabled < MAX_WALLS) ? walls_enabled : MAX_WALLS;
      for (int k = 0; k < scan; k++) begin
         if (!e.blocked && sight_crosses(r, wall_shadow[k])) begin
            e.blocked       = 1'b1;
            e.blocking_wall = k[WALL_IDX_W-1:0];
         end
      end
      e.visible = e.in_fov && !e.blocked;
      return e;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // Responses last one cycle and cannot be held off, so every strobe is
   // checked at the edge that ends it against the oldest expected view.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_views.size() == 0) begin
            $display("%0t response with no query outstanding", $realtime);
            error_count++;
         end else begin
            rsp_type want;
            want = pending_views.pop_front();
            if (rsp.visible !== want.visible)
               report_mismatch("visible", rsp.visible, want.visible);
            if (rsp.in_fov !== want.in_fov)
               report_mismatch("in_fov", rsp.in_fov, want.in_fov);
            if (rsp.blocked !== want.blocked)
               report_mismatch("blocked", rsp.blocked, want.blocked);
            if (rsp.blocking_wall !== want.blocking_wall)
               report_mismatch("blocking_wall", rsp.blocking_wall, want.blocking_wall);
         end
      end
   end

   // Holds start high until the request is taken. Start is left high so a
   // back-to-back request does not drop it in the same time step.
   task automatic send_request(req_type r);
      req   <= r;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      if (r.mode == MODE_LOAD) begin
         wall_shadow[r.wall_index] = '{r.wall_x0, r.wall_y0, r.wall_x1, r.wall_y1};
      end else begin
         pending_views.push_back(view_of(r));
      end
   endtask

   // Random sender gap ahead of a request, set by the current idling phase.
   task automatic maybe_pause();
      if ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // Lowers start and waits for every outstanding response.
   task automatic drain_views();
      start <= 1'b0;
      @(posedge clock);
      while (pending_views.size() != 0) @(posedge clock);
   endtask

   // Registers may change only with nothing in flight, loads included.
   task automatic write_register(logic idx, int value);
      drain_views();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_WALL_COUNT) walls_enabled = value & 'h7F;
      else fov_limit = value & 'hFFFF;
   endtask

   // Coordinates either near the origin, where walls and sight lines meet
   // often, or anywhere in the signed range.
   function automatic logic signed [COORD_BITS-1:0] pick_coord(bit near);
      if (near) return COORD_BITS'($urandom_range(0, 400)) - 16'sd200;
      return COORD_BITS'($urandom);
   endfunction

   function automatic req_type random_load(int slot);
      req_type r;
      bit      near;
      r            = req_type'({$urandom, $urandom, $urandom, $urandom, $urandom});
      near         = ($urandom_range(9) != 0);
      r.mode       = MODE_LOAD;
      r.wall_index = slot[WALL_IDX_W-1:0];
      r.wall_x0    = pick_coord(near);
      r.wall_y0    = pick_coord(near);
      r.wall_x1    = pick_coord(near);
      r.wall_y1    = pick_coord(near);
      return r;
   endfunction

   function automatic req_type random_query();
      req_type r;
      bit      near;
      r          = req_type'({$urandom, $urandom, $urandom, $urandom, $urandom});
      near       = ($urandom_range(9) != 0);
      r.mode     = MODE_QUERY;
      r.player_x = pick_coord(near);
      r.player_y = pick_coord(near);
      r.aim_x    = pick_coord(near);
      r.aim_y    = pick_coord(near);
      // Now and then the target sits right on the player.
      if ($urandom_range(19) == 0) begin
         r.aim_x = r.player_x;
         r.aim_y = r.player_y;
      end
      return r;
   endfunction

   function automatic req_type make_query(int px, int py, int face, int tx, int ty);
      req_type r;
      r              = '0;
      r.mode         = MODE_QUERY;
      r.player_x     = px[15:0];
      r.player_y     = py[15:0];
      r.facing_angle = face[15:0];
      r.aim_x        = tx[15:0];
      r.aim_y        = ty[15:0];
      return r;
   endfunction

   function automatic req_type make_wall(int slot, int x0, int y0, int x1, int y1);
      req_type r;
      r            = '0;
      r.mode       = MODE_LOAD;
      r.wall_index = slot[WALL_IDX_W-1:0];
      r.wall_x0    = x0[15:0];
      r.wall_y0    = y0[15:0];
      r.wall_x1    = x1[15:0];
      r.wall_y1    = y1[15:0];
      return r;
   endfunction

   // With no walls enabled no wall is tested, so the bearing and the
   // field-of-view window can be probed right after reset: coordinate
   // extremes, the four compass directions, and the target on the player.
   task automatic test_bearing_extremes();
      send_request(make_query(0, 0, 0, 0, -100));
      send_request(make_query(0, 0, 0, 100, 0));
      send_request(make_query(0, 0, 16384, 100, 0));
      send_request(make_query(0, 0, 32768, 0, 100));
      send_request(make_query(0, 0, 49152, -100, 0));
      send_request(make_query(5, 5, 65535, 5, 5));
      send_request(make_query(-32768, 32767, 8192, 32767, -32768));
      send_request(make_query(32767, -32768, 40000, -32768, 32767));
      send_request(make_query(-32768, -32768, 0, 32767, 32767));
      // Edges of the default window.
      send_request(make_query(0, 0, 8192, 0, -50));
      send_request(make_query(0, 0, 57344, 0, -50));
      write_register(CSR_FOV_HALF, 0);
      send_request(make_query(0, 0, 0, 0, -7));
      send_request(make_query(0, 0, 1, 0, -7));
      write_register(CSR_FOV_HALF, 32768);
      send_request(make_query(0, 0, 0, 0, 9));
      send_request(make_query(0, 0, 12345, -3, 1));
   endtask

   // Every slot is written before any wall is scanned.
   task automatic test_table_fill();
      for (int k = 0; k < MAX_WALLS; k++) send_request(random_load(k));
   endtask

   // Crossing, touching at an end point, collinear but disjoint, and a
   // blocked target out of view, with the lower slot winning on a tie.
   task automatic test_wall_cases();
      send_request(make_wall(0, 10, -10, 10, 10));
      send_request(make_wall(1, 100, -5, 100, 5));
      send_request(make_wall(2, 200, 0, 300, 0));
      write_register(CSR_WALL_COUNT, 3);
      write_register(CSR_FOV_HALF, 8192);
      send_request(make_query(0, 0, 16384, 50, 0));
      send_request(make_query(0, 0, 16384, 150, 0));
      send_request(make_query(0, 0, 16384, 5, 0));
      send_request(make_query(0, 0, 16384, 10, 10));
      send_request(make_query(0, 0, 16384, 150, 100));
      send_request(make_query(0, 0, 0, 120, 0));
      send_request(make_query(0, 1, 16384, 0, 1));
      drain_views();
   endtask

   // One random phase: mostly queries, some reloads of random slots.
   task automatic run_phase(int count, int idle_pct);
      sender_idle_pct = idle_pct;
      for (int n = 0; n < count; n++) begin
         maybe_pause();
         if ($urandom_range(4) == 0) send_request(random_load($urandom_range(0, 63)));
         else send_request(random_query());
         // Once in a while the sender waits for the engine to empty out.
         if ($urandom_range(99) == 0) drain_views();
      end
      drain_views();
   endtask

   task automatic test_random_sweep();
      int counts [6] = '{0, 1, 64, 100, 127, 17};
      int fovs   [6] = '{0, 32768, 65535, 8192, 1, 20000};
      int idles  [3] = '{0, 84, 9};
      for (int p = 0; p < 6; p++) begin
         write_register(CSR_WALL_COUNT, counts[p]);
         write_register(CSR_FOV_HALF, fovs[p]);
         for (int q = 0; q < 3; q++) run_phase(58, idles[q]);
      end
      write_register(CSR_WALL_COUNT, $urandom_range(2, 64));
      write_register(CSR_FOV_HALF, $urandom_range(0, 32768));
      run_phase(40, 84);
   endtask

   initial begin
      int spin;
      error_count   = 0;
      walls_enabled = 0;
      fov_limit     = 8192;
      sender_idle_pct = 0;
      reset     = 1'b1;
      start     = 1'b0;
      req       = '0;
      csr_we    = 1'b0;
      csr_index = CSR_WALL_COUNT;
      csr_wdata = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_bearing_extremes();
      test_table_fill();
      test_wall_cases();
      test_random_sweep();

      start <= 1'b0;
      spin = 0;
      while (pending_views.size() != 0 && spin < 100000) begin
         @(posedge clock);
         spin++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_views.size() == 0) begin
         $display("line_of_sight_test test passed");
      end else begin
         $display("line_of_sight_test test failed");
      end
      $finish;
   end

endmodule
